// File: src/ps2md_pkg.sv
// Shared types and constants for the PS/2 mouse packet decoder.
package ps2md_pkg;

    // Packet ring
    localparam int FIFO_DEPTH = 64;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);

    // Read requests
    localparam int MAX_RESULTS = 64;
    localparam int CNT_W       = 7;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int DELTA_W = 9;
    localparam int BTN_W   = 3;
    localparam int PKT_W   = BTN_W + 2 * DELTA_W;

    // Stream widths
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    // Command queue between front and back
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    // Flags byte bit positions
    localparam int FLAG_SYNC = 3;
    localparam int FLAG_SX   = 4;
    localparam int FLAG_SY   = 5;
    localparam int FLAG_OVX  = 6;
    localparam int FLAG_OVY  = 7;

    // Input item kinds
    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_READ = 1'b1;

    typedef struct packed {
        logic [BTN_W-1:0]   buttons;
        logic [DELTA_W-1:0] dy;
        logic [DELTA_W-1:0] dx;
    } packet_t;

    typedef enum logic [0:0] {
        CMD_PUSH = 1'b0,
        CMD_READ = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [CNT_W-1:0] count;
        packet_t          pkt;
    } cmd_t;

endpackage

// File: src/ps2md_front.sv
// Front end: accepts stream items, assembles 3-byte packets, issues commands.
module ps2md_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ps2md_pkg::S_TDATA_W-1:0]  s_tdata,   // [7:0] rx_byte, [14:8] max_count
    input  logic                             s_tuser,   // [0] mode
    input  logic                             q_full,
    output logic                             q_push,
    output ps2md_pkg::cmd_t                  q_cmd
);

    localparam logic [1:0] POS_FLAGS = 2'd0;
    localparam logic [1:0] POS_DX    = 2'd1;
    localparam logic [1:0] POS_DY    = 2'd2;

    logic [1:0]                        pos_reg, pos_next;
    logic [ps2md_pkg::BYTE_W-1:0]      flags_reg, flags_next;
    logic [ps2md_pkg::BYTE_W-1:0]      dx_reg, dx_next;
    logic                              accept;
    logic [ps2md_pkg::BYTE_W-1:0]      rx_byte;
    logic [ps2md_pkg::CNT_W-1:0]       max_count;
    logic [ps2md_pkg::CNT_W-1:0]       count_sat;

    assign s_tready  = ~q_full;
    assign accept    = s_tvalid & ~q_full;
    assign rx_byte   = s_tdata[ps2md_pkg::BYTE_W-1:0];
    assign max_count = s_tdata[ps2md_pkg::BYTE_W +: ps2md_pkg::CNT_W];
    assign count_sat = (max_count > ps2md_pkg::CNT_W'(ps2md_pkg::MAX_RESULTS)) ?
                       ps2md_pkg::CNT_W'(ps2md_pkg::MAX_RESULTS) : max_count;

    // Classify the transfer and build the command
    always_comb begin
        pos_next              = pos_reg;
        flags_next            = flags_reg;
        dx_next               = dx_reg;
        q_push                = 1'b0;
        q_cmd.kind            = ps2md_pkg::CMD_PUSH;
        q_cmd.count           = count_sat;
        q_cmd.pkt.dx          = {flags_reg[ps2md_pkg::FLAG_SX], dx_reg};
        q_cmd.pkt.dy          = {flags_reg[ps2md_pkg::FLAG_SY], rx_byte};
        q_cmd.pkt.buttons     = flags_reg[ps2md_pkg::BTN_W-1:0];
        if (accept) begin
            if (s_tuser == ps2md_pkg::MODE_READ) begin
                q_cmd.kind = ps2md_pkg::CMD_READ;
                q_push     = (count_sat != '0);
            end else begin
                case (pos_reg)
                    POS_FLAGS: begin
                        // resync: a first byte must have bit 3 set
                        if (rx_byte[ps2md_pkg::FLAG_SYNC]) begin
                            flags_next = rx_byte;
                            pos_next   = POS_DX;
                        end
                    end
                    POS_DX: begin
                        dx_next  = rx_byte;
                        pos_next = POS_DY;
                    end
                    default: begin
                        pos_next = POS_FLAGS;
                        // drop packets with an overflow flag
                        q_push   = ~(flags_reg[ps2md_pkg::FLAG_OVX] |
                                     flags_reg[ps2md_pkg::FLAG_OVY]);
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= POS_FLAGS;
        end else begin
            pos_reg <= pos_next;
        end
    end

    // Held bytes need no reset
    always_ff @(posedge aclk) begin
        flags_reg <= flags_next;
        dx_reg    <= dx_next;
    end

endmodule

// File: src/ps2md_cmdq.sv
// Short command queue decoupling the front end from the ring back end.
module ps2md_cmdq (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  ps2md_pkg::cmd_t push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            valid,
    output ps2md_pkg::cmd_t head
);

    ps2md_pkg::cmd_t                     slots_reg [ps2md_pkg::CMDQ_DEPTH];
    logic [ps2md_pkg::CMDQ_PTR_W-1:0]    wr_reg, wr_next;
    logic [ps2md_pkg::CMDQ_PTR_W-1:0]    rd_reg, rd_next;
    logic [ps2md_pkg::CMDQ_CNT_W-1:0]    cnt_reg, cnt_next;
    logic                                do_push, do_pop;

    assign full    = (cnt_reg == ps2md_pkg::CMDQ_CNT_W'(ps2md_pkg::CMDQ_DEPTH));
    assign valid   = (cnt_reg != '0);
    assign head    = slots_reg[rd_reg];
    assign do_push = push & ~full;
    assign do_pop  = pop & valid;

    // Pointer and occupancy update
    always_comb begin
        wr_next  = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop  ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_reg] <= push_cmd;
        end
    end

endmodule

// File: src/ps2md_back.sv
// Back end: packet ring buffer, read sequencer and output register.
module ps2md_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             q_valid,
    input  ps2md_pkg::cmd_t                  q_cmd,
    output logic                             q_pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ps2md_pkg::M_TDATA_W-1:0]  m_tdata,   // [8:0] delta_x, [17:9] delta_y, [20:18] button_bits
    output logic                             m_tuser,   // [0] present
    output logic                             m_tlast
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_FETCH = 3'b010,
        ST_EMIT  = 3'b100
    } state_t;

    state_t                          state_reg, state_next;
    logic [ps2md_pkg::PTR_W-1:0]     wr_reg, wr_next;
    logic [ps2md_pkg::PTR_W-1:0]     rd_reg, rd_next;
    logic [ps2md_pkg::CNT_W-1:0]     remain_reg, remain_next;
    logic [ps2md_pkg::PTR_W-1:0]     wr_inc, rd_inc;
    logic                            out_free;
    logic                            mem_we;
    logic                            fetch;
    logic                            out_load;
    logic                            out_valid_reg, out_valid_next;
    ps2md_pkg::packet_t              out_pkt_reg, out_pkt_next;
    logic                            out_present_reg, out_present_next;
    logic                            out_last_reg, out_last_next;
    ps2md_pkg::packet_t              ring_mem [ps2md_pkg::FIFO_DEPTH];
    ps2md_pkg::packet_t              rdata_reg;

    assign wr_inc   = (wr_reg == ps2md_pkg::PTR_W'(ps2md_pkg::FIFO_DEPTH - 1)) ?
                      '0 : wr_reg + 1'b1;
    assign rd_inc   = (rd_reg == ps2md_pkg::PTR_W'(ps2md_pkg::FIFO_DEPTH - 1)) ?
                      '0 : rd_reg + 1'b1;
    assign out_free = ~out_valid_reg | m_tready;
    assign q_pop    = (state_reg == ST_IDLE) & q_valid & out_free;

    // Sequencer
    always_comb begin
        state_next       = state_reg;
        wr_next          = wr_reg;
        rd_next          = rd_reg;
        remain_next      = remain_reg;
        mem_we           = 1'b0;
        fetch            = 1'b0;
        out_load         = 1'b0;
        out_pkt_next     = out_pkt_reg;
        out_present_next = out_present_reg;
        out_last_next    = out_last_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_pop) begin
                    if (q_cmd.kind == ps2md_pkg::CMD_PUSH) begin
                        // full ring keeps one slot free; drop when full
                        if (wr_inc != rd_reg) begin
                            mem_we  = 1'b1;
                            wr_next = wr_inc;
                        end
                    end else if (rd_reg == wr_reg) begin
                        // empty ring: single not-present result
                        out_load         = 1'b1;
                        out_pkt_next     = '0;
                        out_present_next = 1'b0;
                        out_last_next    = 1'b1;
                    end else begin
                        remain_next = q_cmd.count;
                        state_next  = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                fetch      = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_load         = 1'b1;
                    out_pkt_next     = rdata_reg;
                    out_present_next = 1'b1;
                    out_last_next    = (remain_reg == ps2md_pkg::CNT_W'(1)) ||
                                       (rd_inc == wr_reg);
                    rd_next          = rd_inc;
                    remain_next      = remain_reg - 1'b1;
                    state_next       = out_last_next ? ST_IDLE : ST_FETCH;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = out_load | (out_valid_reg & ~m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            wr_reg        <= '0;
            rd_reg        <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            wr_reg        <= wr_next;
            rd_reg        <= rd_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        out_pkt_reg     <= out_pkt_next;
        out_present_reg <= out_present_next;
        out_last_reg    <= out_last_next;
    end

    // Ring memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ring_mem[wr_reg] <= q_cmd.pkt;
        end
        if (fetch) begin
            rdata_reg <= ring_mem[rd_reg];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(ps2md_pkg::M_TDATA_W - ps2md_pkg::PKT_W)'(0), out_pkt_reg};
    assign m_tuser  = out_present_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTH
    // A read in progress always has packets left in the ring
    a_busy_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (rd_reg != wr_reg))
        else $error("read sequencer active on empty ring");

    // A read in progress always has count left
    a_busy_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (remain_reg != '0))
        else $error("read sequencer active with zero count");

    // No packet is written while a read is in progress
    a_wr_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |=> (wr_reg == $past(wr_reg)))
        else $error("write pointer moved during a read");

    // Output register never overwritten while a result waits
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |-> !out_load)
        else $error("pending result overwritten");
`endif

endmodule

// File: src/ps2_mouse_packet_decoder_fifo.sv
// Top level: PS/2 mouse 3-byte packet decoder with a packet ring buffer.
// A read's first result passes from the command queue through the fetch state, the ring read
// register and the output register; a read of an empty ring loads its not-present result from idle.
// Throughput: one input transfer per cycle while the 4-entry command queue has room; a read
// fetches each packet from ring memory and loads it into the output register before the next fetch.
// Reset (aresetn low, synchronous) clears byte position, queue, ring pointers and output
// valid; the ring memory is not cleared and needs no clearing pass.
module ps2_mouse_packet_decoder_fifo (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ps2md_pkg::S_TDATA_W-1:0]  s_tdata,   // [7:0] rx_byte, [14:8] max_count
    input  logic                             s_tuser,   // [0] mode
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ps2md_pkg::M_TDATA_W-1:0]  m_tdata,   // [8:0] delta_x, [17:9] delta_y, [20:18] button_bits
    output logic                             m_tuser,   // [0] present
    output logic                             m_tlast
);

    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_valid;
    ps2md_pkg::cmd_t push_cmd;
    ps2md_pkg::cmd_t head_cmd;

    ps2md_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    ps2md_cmdq u_cmdq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (head_cmd)
    );

    ps2md_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_cmd    (head_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the PS/2 mouse packet decoder with its packet ring.
`timescale 1ns / 100ps

// One result as it leaves the block
typedef struct packed {
    logic                          present;
    logic [ps2md_pkg::DELTA_W-1:0] dx;
    logic [ps2md_pkg::DELTA_W-1:0] dy;
    logic [ps2md_pkg::BTN_W-1:0]   buttons;
    logic                          last;
} mouse_report_t;

// Shadow of the decoder and ring; holds the reports still owed by the block
class mouse_report_board;
    ps2md_pkg::packet_t          ring [ps2md_pkg::FIFO_DEPTH];
    logic [ps2md_pkg::PTR_W-1:0] wr_slot;
    logic [ps2md_pkg::PTR_W-1:0] rd_slot;
    logic [1:0]                  byte_pos;
    logic [7:0]                  held [2];
    mouse_report_t               owed [$];
    int                          errors;

    function new();
        wr_slot  = '0;
        rd_slot  = '0;
        byte_pos = '0;
        errors   = 0;
    endfunction

    // Packet assembly: sync check on the first byte, overflow drop, full-ring drop
    function void take_byte(logic [7:0] b);
        ps2md_pkg::packet_t pkt;
        if (byte_pos == 2'd0 && !b[ps2md_pkg::FLAG_SYNC])
            return;
        if (byte_pos < 2'd2) begin
            held[byte_pos] = b;
            byte_pos++;
            return;
        end
        byte_pos = 2'd0;
        if (held[0][ps2md_pkg::FLAG_OVY] || held[0][ps2md_pkg::FLAG_OVX])
            return;
        if (ps2md_pkg::PTR_W'(wr_slot + 1'b1) == rd_slot)
            return;
        pkt.dx      = {held[0][ps2md_pkg::FLAG_SX], held[1]};
        pkt.dy      = {held[0][ps2md_pkg::FLAG_SY], b};
        pkt.buttons = held[0][ps2md_pkg::BTN_W-1:0];
        ring[wr_slot] = pkt;
        wr_slot++;
    endfunction

    // Note one accepted input transfer
    function void note_input(logic mode, logic [7:0] b, logic [ps2md_pkg::CNT_W-1:0] cnt);
        mouse_report_t r;
        int            limit;
        int            taken;
        if (mode == ps2md_pkg::MODE_BYTE) begin
            take_byte(b);
            return;
        end
        if (cnt == '0)
            return;
        limit = (cnt > ps2md_pkg::MAX_RESULTS) ? ps2md_pkg::MAX_RESULTS : int'(cnt);
        if (rd_slot == wr_slot) begin
            r = '0;
            r.last = 1'b1;
            owed.push_back(r);
            return;
        end
        taken = 0;
        while (taken < limit && rd_slot != wr_slot) begin
            r.present = 1'b1;
            r.dx      = ring[rd_slot].dx;
            r.dy      = ring[rd_slot].dy;
            r.buttons = ring[rd_slot].buttons;
            rd_slot++;
            taken++;
            r.last = (taken == limit) || (rd_slot == wr_slot);
            owed.push_back(r);
        end
    endfunction

    task report(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    // Compare one output transfer with the oldest owed report
    task check_result(mouse_report_t got);
        mouse_report_t exp;
        if (owed.size() == 0) begin
            report($sformatf("unexpected result %h", got));
            return;
        end
        exp = owed.pop_front();
        if (got.present !== exp.present)
            report($sformatf("present %b, want %b", got.present, exp.present));
        if (got.dx !== exp.dx)
            report($sformatf("delta_x %h, want %h", got.dx, exp.dx));
        if (got.dy !== exp.dy)
            report($sformatf("delta_y %h, want %h", got.dy, exp.dy));
        if (got.buttons !== exp.buttons)
            report($sformatf("buttons %h, want %h", got.buttons, exp.buttons));
        if (got.last !== exp.last)
            report($sformatf("last %b, want %b", got.last, exp.last));
    endtask

    task flush_check();
        if (owed.size() != 0)
            report($sformatf("%0d results never arrived", owed.size()));
    endtask
endclass

module testbench;

    localparam int HALF_PERIOD  = 4;
    localparam int IDLE_LIMIT   = 5000;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 40;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } stall_style_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [ps2md_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic                            s_tuser = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [ps2md_pkg::M_TDATA_W-1:0] m_tdata;
    logic                            m_tuser;
    logic                            m_tlast;

    mouse_report_board board = new();

    int burst_left = 0;
    int items_sent = 0;
    int hold_go    = 0;
    int idle_count = 0;

    ps2_mouse_packet_decoder_fifo u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Receiver: long hold-off on request, otherwise stall styles that change now and then
    always @(posedge aclk) begin
        static int           hold_seen  = 0;
        static int           hold_left  = 0;
        static int           phase_left = 0;
        static stall_style_t style      = STALL_NONE;
        if (hold_go != hold_seen) begin
            hold_seen = hold_go;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (phase_left == 0) begin
                style      = stall_style_t'($urandom_range(0, 3));
                phase_left = $urandom_range(20, 80);
            end
            phase_left--;
            case (style)
                STALL_NONE:   m_tready <= 1'b1;
                STALL_LIGHT:  m_tready <= ($urandom_range(0, 3) != 0);
                STALL_HEAVY:  m_tready <= ($urandom_range(0, 3) == 0);
                default:      m_tready <= ~m_tready;
            endcase
        end
    end

    // Output monitor
    always @(posedge aclk) begin
        mouse_report_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.present = m_tuser;
            got.dx      = m_tdata[ps2md_pkg::DELTA_W-1:0];
            got.dy      = m_tdata[2*ps2md_pkg::DELTA_W-1:ps2md_pkg::DELTA_W];
            got.buttons = m_tdata[ps2md_pkg::PKT_W-1:2*ps2md_pkg::DELTA_W];
            got.last    = m_tlast;
            board.check_result(got);
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Offer one item, in bursts with random gaps; returns once the transfer is done
    task automatic send_item(input logic mode, input logic [7:0] b,
                             input logic [ps2md_pkg::CNT_W-1:0] cnt);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {1'b0, cnt, b};
        do @(posedge aclk); while (!s_tready);
        board.note_input(mode, b, cnt);
        items_sent++;
    endtask

    task automatic send_packet(input logic [7:0] flags, input logic [7:0] x,
                               input logic [7:0] y);
        send_item(ps2md_pkg::MODE_BYTE, flags, ps2md_pkg::CNT_W'($urandom));
        send_item(ps2md_pkg::MODE_BYTE, x, ps2md_pkg::CNT_W'($urandom));
        send_item(ps2md_pkg::MODE_BYTE, y, ps2md_pkg::CNT_W'($urandom));
    endtask

    task automatic send_read(input logic [ps2md_pkg::CNT_W-1:0] cnt);
        send_item(ps2md_pkg::MODE_READ, 8'($urandom), cnt);
    endtask

    // Well-formed flags byte: sync set, no overflow, random signs and buttons
    function automatic logic [7:0] clean_flags();
        logic [7:0] f;
        f = 8'($urandom);
        f[ps2md_pkg::FLAG_OVY] = 1'b0;
        f[ps2md_pkg::FLAG_OVX] = 1'b0;
        f[ps2md_pkg::FLAG_SYNC] = 1'b1;
        return f;
    endfunction

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (board.owed.size() != 0) @(posedge aclk);
    endtask

    initial begin
        logic [7:0] f;
        int         pick;
        int         start_count;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty ring, zero count, sync drops, extremes, overflow, saturation
        send_read(7'd1);
        send_read(7'd0);
        send_item(ps2md_pkg::MODE_BYTE, 8'h00, 7'd0);
        send_item(ps2md_pkg::MODE_BYTE, 8'hF7, 7'h7F);
        send_packet(8'h08, 8'h00, 8'h00);
        send_packet(8'h3F, 8'h00, 8'h00);
        send_packet(8'h38, 8'hFF, 8'hFF);
        send_packet(8'h0D, 8'hFF, 8'h7F);
        send_packet(8'h48, 8'h01, 8'h01);
        send_packet(8'h8A, 8'h02, 8'h02);
        send_read(7'd127);
        send_packet(8'h0A, 8'h12, 8'h34);
        send_read(7'd1);
        send_read(7'd64);
        wait_drained();

        // Fill the ring until a packet is dropped, then drain it with a saturated count
        repeat (ps2md_pkg::FIFO_DEPTH)
            send_packet(clean_flags(), 8'($urandom), 8'($urandom));
        send_read(7'd127);
        send_read(7'd5);

        // Receiver holds off while reads pile up behind it
        hold_go++;
        repeat (4) send_packet(clean_flags(), 8'($urandom), 8'($urandom));
        repeat (8) send_read(7'd2);
        wait_drained();

        // Random traffic: mostly clean packets, some noise, broken packets and reads
        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                f = clean_flags();
                if ($urandom_range(0, 7) == 0)
                    f[$urandom_range(ps2md_pkg::FLAG_OVX, ps2md_pkg::FLAG_OVY)] = 1'b1;
                send_packet(f, 8'($urandom), 8'($urandom));
            end else if (pick < 65) begin
                send_item(ps2md_pkg::MODE_BYTE, 8'($urandom), ps2md_pkg::CNT_W'($urandom));
            end else if (pick < 73) begin
                send_item(ps2md_pkg::MODE_BYTE, clean_flags(), ps2md_pkg::CNT_W'($urandom));
                if ($urandom_range(0, 1) == 1)
                    send_item(ps2md_pkg::MODE_BYTE, 8'($urandom),
                              ps2md_pkg::CNT_W'($urandom));
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    send_read(ps2md_pkg::CNT_W'($urandom_range(1, 6)));
                else if (pick < 85)
                    send_read(ps2md_pkg::CNT_W'($urandom_range(7, 64)));
                else if (pick < 95)
                    send_read(ps2md_pkg::CNT_W'($urandom_range(65, 127)));
                else
                    send_read(7'd0);
            end
        end

        // Wind down
        wait_drained();
        repeat (20) @(posedge aclk);
        board.flush_check();
        if (board.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
